// File: rtl/core/siue_pkg.sv
// Shared types, codes and constants of the staged image update engine.
// No dependencies.
package siue_pkg;

  localparam int unsigned AddrBits        = 20;
  localparam int unsigned PageBytesDef    = 4096;
  localparam int unsigned MaxChunkDef     = 128;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] MetaMagic = 32'h32465055;
  localparam logic [31:0] SpLow     = 32'h20000000;
  localparam logic [31:0] SpHigh    = 32'h20040000;
  localparam logic [31:0] AllOnes   = 32'hFFFFFFFF;

  localparam logic [AddrBits-1:0] AppBaseRst    = 20'd155648;
  localparam logic [AddrBits-1:0] AppEndRst     = 20'd970752;
  localparam logic [AddrBits-1:0] CommitPageRst = 20'd966656;
  localparam logic [AddrBits-1:0] RunEndRst     = 20'd0;
  localparam logic [AddrBits-1:0] MaxImageRst   = 20'd393216;

  typedef enum logic [2:0] {
    REG_APP_BASE    = 3'd0,
    REG_APP_END     = 3'd1,
    REG_COMMIT_PAGE = 3'd2,
    REG_RUN_END     = 3'd3,
    REG_MAX_IMAGE   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_WORD   = 3'd2,
    CMD_END    = 3'd3,
    CMD_ABORT  = 3'd4,
    CMD_BAD    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BOUNDS = 3'd1,
    ST_STATE  = 3'd2,
    ST_OFFSET = 3'd3,
    ST_CRC    = 3'd4,
    ST_VECTOR = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_ERASE = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef struct packed {
    logic [AddrBits-1:0] code_base;
    logic [AddrBits-1:0] app_end;
    logic [AddrBits-1:0] commit_page;
    logic [AddrBits-1:0] run_end;
    logic [AddrBits-1:0] max_image;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] size_or_offset;
    logic [31:0] expected_crc;
    logic [7:0]  chunk_len;
    logic [31:0] data_word;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [AddrBits-1:0] next_offset;
    op_e                 op;
    logic [AddrBits-1:0] addr;
    logic [31:0]         data;
    logic                last;
  } res_t;

  // CRC-32 (reflected) over one little-endian word; a pure XOR network
  function automatic logic [31:0] crc_word(input logic [31:0] crc_in, input logic [31:0] w);
    logic [31:0] c;
    c = crc_in ^ w;
    for (int i = 0; i < 32; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic cmd_e classify(input logic [2:0] code);
    cmd_e c;
    case (code)
      3'd0:    c = CMD_BEGIN;
      3'd1:    c = CMD_HEADER;
      3'd2:    c = CMD_WORD;
      3'd3:    c = CMD_END;
      3'd4:    c = CMD_ABORT;
      default: c = CMD_BAD;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/siue_queue.sv
// Front part: accepts commands, classifies the opcode and queues them.
// Depends on siue_pkg.
module siue_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           command_i,
  input  logic [31:0]          size_or_offset_i,
  input  logic [31:0]          expected_crc_i,
  input  logic [7:0]           chunk_len_i,
  input  logic [31:0]          data_word_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output siue_pkg::item_t      q_item_o
);
  import siue_pkg::*;

  item_t       mem_q [QueueDepth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;

  assign in_stall_o = (count_q == 2'(QueueDepth));
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: classify(command_i), size_or_offset: size_or_offset_i,
                            expected_crc: expected_crc_i, chunk_len: chunk_len_i,
                            data_word: data_word_i};
    end
  end

endmodule

// File: rtl/core/siue_exec.sv
// Back part: runs one queued command at a time, issuing one flash request per
// cycle into an output register whenever it is free. Depends on siue_pkg.
module siue_exec #(
  parameter int unsigned PAGE_BYTES      = siue_pkg::PageBytesDef,
  parameter int unsigned MAX_CHUNK_BYTES = siue_pkg::MaxChunkDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  siue_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  siue_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output siue_pkg::res_t  out_res_o
);
  import siue_pkg::*;

  localparam logic [AddrBits-1:0] PageMask = AddrBits'(PAGE_BYTES - 1);
  localparam logic [AddrBits:0]   PageAdd  = (AddrBits + 1)'(PAGE_BYTES);
  localparam logic [7:0]          MaxChunk = 8'(MAX_CHUNK_BYTES);

  item_t cur_q;
  logic  busy_q, busy_d;
  logic [2:0]  k_q, k_d;
  logic [31:0] mcrc_q, mcrc_d;

  logic                active_q, active_d;
  logic [AddrBits-1:0] size_q, size_d;
  logic [31:0]         tcrc_q, tcrc_d;
  logic [AddrBits-1:0] sbase_q, sbase_d;
  logic [AddrBits-1:0] wo_q, wo_d;
  logic [AddrBits-1:0] erased_q, erased_d;
  logic [31:0]         rcrc_q, rcrc_d;
  logic [5:0]          cwl_q, cwl_d;
  logic                cwrite_q, cwrite_d;
  logic [31:0]         stack_q, stack_d;
  logic [31:0]         rvec_q, rvec_d;
  logic                armed_q, armed_d;

  logic out_valid_q;
  res_t res_q, res;
  logic out_free, emit;

  logic                begin_bad;
  logic [AddrBits-1:0] base;
  logic [32:0]         hdr_sum;
  status_e             hdr_st;
  logic                hdr_take;
  logic [AddrBits:0]   word_end;
  logic                word_skip;
  logic                vec_ok;
  logic [2:0]          k_m1;

  function automatic logic [31:0] meta_word(input logic [2:0] idx,
                                            input logic [AddrBits-1:0] sz,
                                            input logic [31:0] tc,
                                            input logic [AddrBits-1:0] sb);
    logic [31:0] w;
    case (idx)
      3'd0:    w = MetaMagic;
      3'd1:    w = 32'(sz);
      3'd2:    w = tc;
      default: w = 32'(sb);
    endcase
    return w;
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = busy_q && out_free;
  assign q_pop_o     = q_valid_i && (!busy_q || (emit && res.last));
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    base      = (cfg_i.commit_page - cur_q.size_or_offset[AddrBits-1:0]) & ~PageMask;
    begin_bad = (cur_q.size_or_offset == 32'd0)
             || (cur_q.size_or_offset > 32'(cfg_i.max_image))
             || (cur_q.size_or_offset[1:0] != 2'd0)
             || (cur_q.size_or_offset > 32'(cfg_i.commit_page))
             || ({1'b0, base} < ({1'b0, cfg_i.run_end} + PageAdd));

    hdr_sum  = {1'b0, cur_q.size_or_offset} + 33'(cur_q.chunk_len);
    hdr_take = 1'b0;
    if (!active_q) begin
      hdr_st = ST_STATE;
    end else if (cur_q.chunk_len == 8'd0 || cur_q.chunk_len > MaxChunk
                 || cur_q.chunk_len[1:0] != 2'd0 || hdr_sum > 33'(size_q)) begin
      hdr_st = ST_BOUNDS;
    end else if (cur_q.size_or_offset == 32'(wo_q)) begin
      hdr_st   = ST_OK;
      hdr_take = 1'b1;
    end else if (cur_q.size_or_offset < 32'(wo_q) && hdr_sum <= 33'(wo_q)) begin
      hdr_st = ST_OK;
    end else begin
      hdr_st = ST_OFFSET;
    end

    word_end  = {1'b0, sbase_q} + {1'b0, wo_q} + (AddrBits + 1)'(4);
    word_skip = !active_q || !cwrite_q || (cwl_q == 6'd0);

    vec_ok = (size_q >= AddrBits'(8)) && (stack_q >= SpLow) && (stack_q <= SpHigh)
          && (stack_q[1:0] == 2'd0) && rvec_q[0]
          && (rvec_q >= 32'(cfg_i.code_base)) && (rvec_q < 32'(cfg_i.app_end));
    k_m1 = k_q - 3'd1;
  end

  always_comb begin
    res      = '{status: ST_OK, next_offset: wo_q, op: OP_NONE, addr: '0, data: '0,
                 last: 1'b1};
    busy_d   = busy_q;
    k_d      = k_q;
    mcrc_d   = mcrc_q;
    active_d = active_q;
    size_d   = size_q;
    tcrc_d   = tcrc_q;
    sbase_d  = sbase_q;
    wo_d     = wo_q;
    erased_d = erased_q;
    rcrc_d   = rcrc_q;
    cwl_d    = cwl_q;
    cwrite_d = cwrite_q;
    stack_d  = stack_q;
    rvec_d   = rvec_q;
    armed_d  = armed_q;

    case (cur_q.cmd)
      CMD_BEGIN: begin
        res.op     = OP_ERASE;
        res.addr   = cfg_i.commit_page;
        res.status = begin_bad ? ST_BOUNDS : ST_OK;
        if (!begin_bad) res.next_offset = '0;
        if (emit) begin
          active_d = 1'b0;
          armed_d  = 1'b0;
          cwrite_d = 1'b0;
          cwl_d    = '0;
          if (!begin_bad) begin
            size_d   = cur_q.size_or_offset[AddrBits-1:0];
            tcrc_d   = cur_q.expected_crc;
            sbase_d  = base;
            wo_d     = '0;
            erased_d = base;
            rcrc_d   = AllOnes;
            stack_d  = '0;
            rvec_d   = '0;
            active_d = 1'b1;
          end
        end
      end
      CMD_HEADER: begin
        res.status = hdr_st;
        if (emit) begin
          cwl_d    = cur_q.chunk_len[7:2];
          cwrite_d = hdr_take;
        end
      end
      CMD_WORD: begin
        if (word_skip) begin
          res.status = active_q ? ST_OK : ST_STATE;
          if (emit) begin
            if (cwl_q != 6'd0) cwl_d = cwl_q - 6'd1;
            if (cwl_q <= 6'd1) cwrite_d = 1'b0;
          end
        end else if (({1'b0, erased_q} < word_end) && (k_q < 3'd2)) begin
          // erase the next page before writing into it
          res.op   = OP_ERASE;
          res.addr = erased_q;
          res.last = 1'b0;
          if (emit) begin
            erased_d = erased_q + PageAdd[AddrBits-1:0];
            k_d      = k_q + 3'd1;
          end
        end else begin
          res.op          = OP_WRITE;
          res.addr        = sbase_q + wo_q;
          res.data        = cur_q.data_word;
          res.next_offset = wo_q + AddrBits'(4);
          if (emit) begin
            rcrc_d = crc_word(rcrc_q, cur_q.data_word);
            if (wo_q == AddrBits'(0)) stack_d = cur_q.data_word;
            else if (wo_q == AddrBits'(4)) rvec_d = cur_q.data_word;
            wo_d  = wo_q + AddrBits'(4);
            cwl_d = cwl_q - 6'd1;
            if (cwl_q == 6'd1) cwrite_d = 1'b0;
          end
        end
      end
      CMD_END: begin
        if (!active_q) begin
          res.status = (armed_q && size_q != '0) ? ST_OK : ST_STATE;
        end else if (wo_q != size_q) begin
          res.status = ST_STATE;
        end else if ((rcrc_q ^ AllOnes) != tcrc_q || !vec_ok) begin
          res.status = ((rcrc_q ^ AllOnes) != tcrc_q) ? ST_CRC : ST_VECTOR;
          if (emit) begin
            active_d = 1'b0;
            cwrite_d = 1'b0;
            cwl_d    = '0;
          end
        end else begin
          // commit run: erase, then magic, size, crc, base, record crc
          res.last = (k_q == 3'd5);
          if (k_q == 3'd0) begin
            res.op   = OP_ERASE;
            res.addr = cfg_i.commit_page;
          end else begin
            res.op   = OP_WRITE;
            res.addr = cfg_i.commit_page + AddrBits'({k_m1, 2'b00});
            res.data = (k_q == 3'd5) ? (mcrc_q ^ AllOnes)
                                     : meta_word(k_m1, size_q, tcrc_q, sbase_q);
          end
          if (emit) begin
            k_d = k_q + 3'd1;
            if (k_q < 3'd4) mcrc_d = crc_word(mcrc_q, meta_word(k_q, size_q, tcrc_q, sbase_q));
            if (k_q == 3'd5) begin
              active_d = 1'b0;
              cwrite_d = 1'b0;
              cwl_d    = '0;
              armed_d  = 1'b1;
            end
          end
        end
      end
      CMD_ABORT: begin
        res.op   = OP_ERASE;
        res.addr = cfg_i.commit_page;
        if (emit) begin
          active_d = 1'b0;
          armed_d  = 1'b0;
          cwrite_d = 1'b0;
          cwl_d    = '0;
        end
      end
      default: begin
        res.status = ST_STATE;
      end
    endcase

    if (emit && res.last) busy_d = 1'b0;
    if (q_pop_o) begin
      busy_d = 1'b1;
      k_d    = '0;
      mcrc_d = AllOnes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      size_q      <= '0;
      tcrc_q      <= '0;
      sbase_q     <= '0;
      wo_q        <= '0;
      erased_q    <= '0;
      rcrc_q      <= AllOnes;
      cwl_q       <= '0;
      cwrite_q    <= 1'b0;
      stack_q     <= '0;
      rvec_q      <= '0;
      armed_q     <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      k_q         <= k_d;
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      active_q    <= active_d;
      size_q      <= size_d;
      tcrc_q      <= tcrc_d;
      sbase_q     <= sbase_d;
      wo_q        <= wo_d;
      erased_q    <= erased_d;
      rcrc_q      <= rcrc_d;
      cwl_q       <= cwl_d;
      cwrite_q    <= cwrite_d;
      stack_q     <= stack_d;
      rvec_q      <= rvec_d;
      armed_q     <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcrc_q <= mcrc_d;
    if (q_pop_o) cur_q <= q_item_i;
    if (emit) res_q <= res;
  end

endmodule

// File: rtl/core/staged_image_update_engine_top.sv
// Top level of the staged image update engine: configuration registers,
// command queue and executor. Depends on siue_pkg, siue_queue, siue_exec.
//
// Each accepted command yields a run of one to six result words, the last one
// flagged with out_last_o and carrying the status. The executor issues one
// result word per cycle whenever the output register is free: a data word
// yields up to two page erases and the write, and a successful end yields
// an erase and five metadata writes. A two-entry queue in front keeps
// accepting commands while results wait to be taken.
module staged_image_update_engine_top #(
  parameter int unsigned PAGE_BYTES      = siue_pkg::PageBytesDef,
  parameter int unsigned MAX_CHUNK_BYTES = siue_pkg::MaxChunkDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_command_i,
  input  logic [31:0] in_size_or_offset_i,
  input  logic [31:0] in_expected_crc_i,
  input  logic [7:0]  in_chunk_len_i,
  input  logic [31:0] in_data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_status_o,
  output logic [19:0] out_next_offset_o,
  output logic [1:0]  out_flash_op_o,
  output logic [19:0] out_flash_addr_o,
  output logic [31:0] out_flash_data_o,
  output logic        out_last_o
);
  import siue_pkg::*;

  cfg_t  cfg_q;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{code_base: AppBaseRst, app_end: AppEndRst, commit_page: CommitPageRst,
                 run_end: RunEndRst, max_image: MaxImageRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_APP_BASE:    cfg_q.code_base   <= cfg_data_i;
        REG_APP_END:     cfg_q.app_end     <= cfg_data_i;
        REG_COMMIT_PAGE: cfg_q.commit_page <= cfg_data_i;
        REG_RUN_END:     cfg_q.run_end     <= cfg_data_i;
        REG_MAX_IMAGE:   cfg_q.max_image   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  siue_queue u_queue (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (in_command_i),
    .size_or_offset_i (in_size_or_offset_i),
    .expected_crc_i   (in_expected_crc_i),
    .chunk_len_i      (in_chunk_len_i),
    .data_word_i      (in_data_word_i),
    .q_valid_o        (q_valid),
    .q_pop_i          (q_pop),
    .q_item_o         (q_item)
  );

  siue_exec #(
    .PAGE_BYTES      (PAGE_BYTES),
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign out_status_o      = res.status;
  assign out_next_offset_o = res.next_offset;
  assign out_flash_op_o    = res.op;
  assign out_flash_addr_o  = res.addr;
  assign out_flash_data_o  = res.data;
  assign out_last_o        = res.last;

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> out_status_o == ST_OK)
    else $error("non-final result carries a status");

  a_idle_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_flash_op_o == OP_NONE |-> out_flash_addr_o == '0)
    else $error("address on a result without flash request");

  a_data_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_flash_op_o != OP_WRITE |-> out_flash_data_o == '0)
    else $error("data on a result that is not a write");

endmodule

// File: test/tb_staged_image_update_engine_top.sv
// Testbench of the staged image update engine: directed table, then random update sessions.
// Depends on siue_pkg and staged_image_update_engine_top; predicts every result word itself.
module tb_staged_image_update_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import siue_pkg::*;

  localparam int unsigned PageB = 4096;
  localparam int unsigned MaxChunk = 128;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] so;
    logic [31:0] ec;
    logic [7:0]  len;
    logic [31:0] dw;
    bit          known;
    status_e     st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [19:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic [31:0] in_so = '0, in_ec = '0, in_dw = '0;
  logic [7:0] in_len = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [19:0] out_next_offset, out_addr;
  logic [1:0] out_op;
  logic [31:0] out_data;
  logic out_last;

  staged_image_update_engine_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_command_i(in_cmd), .in_size_or_offset_i(in_so), .in_expected_crc_i(in_ec),
    .in_chunk_len_i(in_len), .in_data_word_i(in_dw),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_status_o(out_status), .out_next_offset_o(out_next_offset),
    .out_flash_op_o(out_op), .out_flash_addr_o(out_addr), .out_flash_data_o(out_data),
    .out_last_o(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // engine copy
  logic [19:0] m_code_base, m_app_end, m_commit, m_run_end, m_max_img;
  bit          m_active, m_armed;
  logic [19:0] m_size, m_base, m_woff, m_erased;
  logic [31:0] m_tcrc, m_crc, m_sp, m_rv;
  logic [5:0]  m_left;
  bit          m_writing;

  res_t flash_reqs[$];
  int   errors = 0;
  int   n_words = 0;
  int   n_items = 0;
  int   cycles = 0;
  int   idle_pct = 0, stall_pct = 0;
  bit   hold_out = 1'b0;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
    logic [31:0] r;
    r = c;
    for (int b = 0; b < 4; b++) begin
      r ^= (w >> (8 * b)) & 32'hFF;
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

  function automatic void push_req(status_e st, op_e op, logic [19:0] a, logic [31:0] d,
                                   logic l);
    res_t r;
    r.status = st; r.next_offset = m_woff; r.op = op; r.addr = a; r.data = d; r.last = l;
    flash_reqs.push_back(r);
  endfunction

  function automatic void engine_reset();
    m_code_base = AppBaseRst; m_app_end = AppEndRst; m_commit = CommitPageRst;
    m_run_end = RunEndRst; m_max_img = MaxImageRst;
    m_active = 0; m_armed = 0; m_size = 0; m_base = 0; m_woff = 0; m_erased = 0;
    m_tcrc = 0; m_crc = AllOnes; m_sp = 0; m_rv = 0; m_left = 0; m_writing = 0;
  endfunction

  function automatic void predict_update(logic [2:0] cmd, logic [31:0] so, logic [31:0] ec,
                                         logic [7:0] len, logic [31:0] dw);
    logic [19:0] base, a;
    logic [31:0] meta[5];
    logic [31:0] mc;
    status_e st;
    int n;
    bit ok;
    case (cmd)
      CMD_BEGIN: begin
        m_active = 0; m_armed = 0; m_writing = 0; m_left = 0;
        base = (m_commit - so[19:0]) & ~20'(PageB - 1);
        if (so == 0 || so > m_max_img || so[1:0] != 0 || so > m_commit ||
            64'(base) < 64'(m_run_end) + PageB) begin
          push_req(ST_BOUNDS, OP_ERASE, m_commit, 0, 1);
        end else begin
          m_size = so[19:0]; m_tcrc = ec; m_base = base; m_woff = 0; m_erased = base;
          m_crc = AllOnes; m_sp = 0; m_rv = 0; m_active = 1;
          push_req(ST_OK, OP_ERASE, m_commit, 0, 1);
        end
      end
      CMD_HEADER: begin
        m_left = len[7:2];
        m_writing = 0;
        if (!m_active) st = ST_STATE;
        else if (len == 0 || len > MaxChunk || len[1:0] != 0 ||
                 64'(so) + len > 64'(m_size)) st = ST_BOUNDS;
        else if (so == 32'(m_woff)) begin
          st = ST_OK; m_writing = 1;
        end else if (so < 32'(m_woff) && 64'(so) + len <= 64'(m_woff)) st = ST_OK;
        else st = ST_OFFSET;
        if (m_left == 0) m_writing = 0;
        push_req(st, OP_NONE, 0, 0, 1);
      end
      CMD_WORD: begin
        if (!m_active || !m_writing || m_left == 0) begin
          if (m_left != 0) m_left--;
          if (m_left == 0) m_writing = 0;
          push_req(m_active ? ST_OK : ST_STATE, OP_NONE, 0, 0, 1);
        end else begin
          a = m_base + m_woff;
          n = 0;
          while (64'(m_erased) < 64'(m_base) + m_woff + 4 && n < 2) begin
            push_req(ST_OK, OP_ERASE, m_erased, 0, 0);
            m_erased = m_erased + 20'(PageB);
            n++;
          end
          m_crc = crc_step(m_crc, dw);
          if (m_woff == 0) m_sp = dw;
          else if (m_woff == 4) m_rv = dw;
          m_woff = m_woff + 4;
          m_left--;
          if (m_left == 0) m_writing = 0;
          push_req(ST_OK, OP_WRITE, a, dw, 1);
        end
      end
      CMD_END: begin
        if (!m_active) begin
          push_req((m_armed && m_size != 0) ? ST_OK : ST_STATE, OP_NONE, 0, 0, 1);
        end else if (m_woff != m_size) begin
          push_req(ST_STATE, OP_NONE, 0, 0, 1);
        end else begin
          m_active = 0; m_writing = 0; m_left = 0;
          ok = m_size >= 8 && m_sp >= SpLow && m_sp <= SpHigh && m_sp[1:0] == 0 &&
               m_rv[0] && m_rv >= 32'(m_code_base) && m_rv < 32'(m_app_end);
          if ((m_crc ^ AllOnes) != m_tcrc) push_req(ST_CRC, OP_NONE, 0, 0, 1);
          else if (!ok) push_req(ST_VECTOR, OP_NONE, 0, 0, 1);
          else begin
            meta[0] = MetaMagic; meta[1] = 32'(m_size); meta[2] = m_tcrc;
            meta[3] = 32'(m_base);
            mc = AllOnes;
            for (int i = 0; i < 4; i++) mc = crc_step(mc, meta[i]);
            meta[4] = mc ^ AllOnes;
            push_req(ST_OK, OP_ERASE, m_commit, 0, 0);
            for (int i = 0; i < 5; i++)
              push_req(ST_OK, OP_WRITE, m_commit + 20'(4 * i), meta[i], i == 4);
            m_armed = 1;
          end
        end
      end
      CMD_ABORT: begin
        m_active = 0; m_armed = 0; m_writing = 0; m_left = 0;
        push_req(ST_OK, OP_ERASE, m_commit, 0, 1);
      end
      default: push_req(ST_STATE, OP_NONE, 0, 0, 1);
    endcase
  endfunction

  // checker and output stall
  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      n_words <= n_words + 1;
      if (flash_reqs.size() == 0) begin
        $error("unexpected word: status %0d op %0d", out_status, out_op);
        errors++;
      end else begin
        e = flash_reqs.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_next_offset !== e.next_offset) begin
          $error("next_offset exp %0h got %0h", e.next_offset, out_next_offset);
          errors++;
        end
        if (out_op !== e.op) begin
          $error("flash_op exp %0d got %0d", e.op, out_op); errors++;
        end
        if (out_addr !== e.addr) begin
          $error("flash_addr exp %0h got %0h", e.addr, out_addr); errors++;
        end
        if (out_data !== e.data) begin
          $error("flash_data exp %0h got %0h", e.data, out_data); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
    out_stall <= hold_out || ($urandom_range(99) < stall_pct);
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high between back-to-back words; drop it only when idling
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] so, logic [31:0] ec,
                          logic [7:0] len, logic [31:0] dw);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1; in_cmd <= cmd; in_so <= so; in_ec <= ec; in_len <= len; in_dw <= dw;
    predict_update(cmd, so, ec, len, dw);
    n_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (flash_reqs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [19:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_APP_BASE:    m_code_base = v;
      REG_APP_END:     m_app_end = v;
      REG_COMMIT_PAGE: m_commit = v;
      REG_RUN_END:     m_run_end = v;
      default:         m_max_img = v;
    endcase
  endtask

  // one session: begin, in-order chunks with occasional faults, end
  task automatic run_session(int nwords, bit good);
    logic [31:0] img[$];
    logic [31:0] c;
    int off, clen;
    img.delete();
    for (int i = 0; i < nwords; i++)
      img.push_back(32'({$urandom, $urandom} >> $urandom_range(31)));
    if (nwords > 0 && $urandom_range(3) != 0) img[0] = SpLow + 32'($urandom_range(4095) * 4);
    if (nwords > 1 && $urandom_range(3) != 0) img[1] = 32'(m_code_base) | 32'h1;
    c = AllOnes;
    foreach (img[i]) c = crc_step(c, img[i]);
    c ^= AllOnes;
    if (!good) c ^= 32'(1 << $urandom_range(31));
    send_cmd(CMD_BEGIN, 32'(nwords * 4), c, 0, 0);
    off = 0;
    while (off < nwords * 4) begin
      clen = 4 * $urandom_range(1, 8);
      if (off + clen > nwords * 4) clen = nwords * 4 - off;
      case ($urandom_range(9))
        0: send_cmd(CMD_HEADER, 32'(off + 4), 0, 8'(clen), 0);
        1: send_cmd(CMD_HEADER, 32'(off), 0, 8'(clen + 2), 0);
        2: if (off >= 4) send_cmd(CMD_HEADER, 0, 0, 8'(4), 0);
        3: send_cmd(CMD_END, 0, 0, 0, 0);
        default: ;
      endcase
      send_cmd(CMD_HEADER, 32'(off), $urandom, 8'(clen), $urandom);
      for (int k = 0; k < clen / 4; k++) send_cmd(CMD_WORD, $urandom, 0, 0, img[off / 4 + k]);
      off += clen;
    end
    if ($urandom_range(5) == 0) send_cmd(CMD_WORD, 0, 0, 0, $urandom);
    send_cmd(CMD_END, 0, 0, 0, 0);
    if ($urandom_range(3) == 0) send_cmd(CMD_END, 0, 0, 0, 0);
  endtask

  row_t dir_rows[$];

  initial begin
    row_t r;
    logic [19:0] lim;
    engine_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: commands outside a transfer, begin bounds, then header and word checks inside a transfer
    dir_rows = '{
      '{CMD_WORD,   0, 0, 0, 32'hFFFFFFFF, 1, ST_STATE},
      '{CMD_HEADER, 0, 0, 4, 0,            1, ST_STATE},
      '{CMD_END,    0, 0, 0, 0,            1, ST_STATE},
      '{3'd5,       0, 0, 0, 0,            1, ST_STATE},
      '{3'd6,       32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1, ST_STATE},
      '{CMD_BAD,    0, 0, 0, 0,            1, ST_STATE},
      '{CMD_BEGIN,  0, 0, 0, 0,            1, ST_BOUNDS},
      '{CMD_BEGIN,  6, 0, 0, 0,            1, ST_BOUNDS},
      '{CMD_BEGIN,  32'hFFFFFFFC, 0, 0, 0, 1, ST_BOUNDS},
      '{CMD_ABORT,  0, 0, 0, 0,            1, ST_OK},
      '{CMD_BEGIN,  16, 32'hFFFFFFFF, 0, 0, 1, ST_OK},
      '{CMD_HEADER, 0, 0, 0, 0,            1, ST_BOUNDS},
      '{CMD_HEADER, 0, 0, 8'hFF, 0,        1, ST_BOUNDS},
      '{CMD_HEADER, 0, 0, 20, 0,           1, ST_BOUNDS},
      '{CMD_HEADER, 0, 0, 6, 0,            1, ST_BOUNDS},
      '{CMD_WORD,   0, 0, 0, 0,            0, ST_OK},
      '{CMD_HEADER, 4, 0, 4, 0,            1, ST_OFFSET},
      '{CMD_HEADER, 0, 0, 8, 0,            1, ST_OK},
      '{CMD_WORD,   0, 0, 0, 32'h20000000, 0, ST_OK},
      '{CMD_HEADER, 0, 0, 4, 0,            1, ST_OK},
      '{CMD_WORD,   0, 0, 0, 32'h12345678, 0, ST_OK},
      '{CMD_END,    0, 0, 0, 0,            1, ST_STATE},
      '{CMD_HEADER, 4, 0, 12, 0,           1, ST_OK},
      '{CMD_WORD,   0, 0, 0, 32'h00026001, 0, ST_OK},
      '{CMD_ABORT,  0, 0, 0, 0,            1, ST_OK}
    };
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_cmd(r.cmd, r.so, r.ec, r.len, r.dw);
      if (r.known && flash_reqs[$].status != r.st) begin
        $error("table row %0d: status exp %0d got %0d", i, r.st, flash_reqs[$].status);
        errors++;
      end
    end
    drain();
    // three-word image, then short image and a corrupted checksum
    run_session(3, 1);
    run_session(1, 1);
    run_session(2, 0);
    drain();

    // random phases under several register settings and idle mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        3: begin idle_pct = 29; stall_pct = 29; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      case (ph)
        1: begin
          write_reg(REG_APP_BASE, 20'h00000); write_reg(REG_APP_END, 20'hFFFFF);
          write_reg(REG_COMMIT_PAGE, 20'hFF000); write_reg(REG_RUN_END, 20'h00000);
          write_reg(REG_MAX_IMAGE, 20'hFFFFF);
        end
        2: begin
          write_reg(REG_COMMIT_PAGE, 20'h03000); write_reg(REG_RUN_END, 20'h01000);
          write_reg(REG_MAX_IMAGE, 20'd4);
        end
        3: begin
          write_reg(REG_COMMIT_PAGE, 20'h80800); write_reg(REG_RUN_END, 20'hFFFFF);
          write_reg(REG_MAX_IMAGE, 20'd64); write_reg(REG_APP_BASE, 20'hFFFFF);
          write_reg(REG_APP_END, 20'h00000);
        end
        4: begin
          write_reg(REG_COMMIT_PAGE, CommitPageRst); write_reg(REG_RUN_END, 20'h10000);
          write_reg(REG_MAX_IMAGE, MaxImageRst); write_reg(REG_APP_BASE, AppBaseRst);
          write_reg(REG_APP_END, AppEndRst);
        end
        default: ;
      endcase
      for (int s = 0; s < 3; s++) begin
        lim = (m_max_img < 20'd48) ? m_max_img : 20'd48;
        run_session($urandom_range(1, lim / 4 > 0 ? lim / 4 : 1), $urandom_range(3) != 0);
        // noise
        for (int k = 0; k < 3; k++)
          send_cmd(3'($urandom_range(7)), $urandom_range(3) == 0 ? $urandom : $urandom_range(64),
                   $urandom, 8'($urandom), $urandom);
      end
      if (ph == 4) begin
        // long output hold-off while commands keep arriving
        fork
          begin
            hold_out = 1'b1;
            repeat (300) @(posedge clk);
            hold_out = 1'b0;
          end
          run_session(20, 1);
        join
      end
      drain();
    end

    $display("Covered %0d commands, %0d result words over five register settings", n_items,
             n_words);
    $display("and idle mixes, including sessions with faults and a long output hold-off.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/siue_pkg.sv
rtl/core/siue_queue.sv
rtl/core/siue_exec.sv
rtl/core/staged_image_update_engine_top.sv
test/tb_staged_image_update_engine_top.sv
